>>> hdl/md5_pkg.sv
// ----------------------------------------------------------------------------
// md5_pkg
// Shared types, control word layout and MD5 constant tables for the digest
// unit and its microcode sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package md5_pkg;

	// push source select
	localparam logic [2:0] DSEL_IN    = 3'd0;
	localparam logic [2:0] DSEL_PAD   = 3'd1;
	localparam logic [2:0] DSEL_ZERO  = 3'd2;
	localparam logic [2:0] DSEL_LENLO = 3'd3;
	localparam logic [2:0] DSEL_LENHI = 3'd4;

	// when a step writes the block buffer
	localparam logic [1:0] PUSH_NONE   = 2'd0;
	localparam logic [1:0] PUSH_FIRE   = 2'd1;
	localparam logic [1:0] PUSH_ALWAYS = 2'd2;
	localparam logic [1:0] PUSH_UNLESS = 2'd3;

	// sequencing modes
	localparam logic [2:0] J_FETCH = 3'd0;
	localparam logic [2:0] J_NEXT  = 3'd1;
	localparam logic [2:0] J_ZFILL = 3'd2;
	localparam logic [2:0] J_ROUND = 3'd3;
	localparam logic [2:0] J_RET   = 3'd4;
	localparam logic [2:0] J_EMIT  = 3'd5;

	localparam logic [31:0] INIT_A = 32'h67452301;
	localparam logic [31:0] INIT_B = 32'hefcdab89;
	localparam logic [31:0] INIT_C = 32'h98badcfe;
	localparam logic [31:0] INIT_D = 32'h10325476;

	typedef logic [2:0] step_t;

	typedef struct packed {
		logic [1:0] push_mode;
		logic [2:0] dsel;
		logic       round_en;
		logic       fold_en;
		logic       emit_en;
		logic [2:0] jmode;
		step_t      target;
	} ctl_t;

	typedef struct packed {
		logic in_fire;
		logic in_last;
		logic in_full;
		logic wrap;
		logic pos14;
		logic round_last;
		logic out_fire;
		logic out_final;
	} cond_t;

	function automatic logic [31:0] round_k(input logic [5:0] r);
		logic [31:0] k;
		case (r)
			6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
			6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
			6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
			6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
			6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
			6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
			6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
			6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
			6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
			6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
			6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
			6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
			6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
			6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
			6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
			6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
			6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
			6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
			6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
			6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
			6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
			6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
			6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
			6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
			6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
			6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
			6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
			6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
			6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
			6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
			6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
			6'd62: k = 32'h2ad7d2bb;  6'd63: k = 32'heb86d391;
			default: k = 32'h0;
		endcase
		return k;
	endfunction

	function automatic logic [4:0] rot_amt(input logic [5:0] r);
		logic [4:0] s;
		case ({r[5:4], r[1:0]})
			4'd0:  s = 5'd7;   4'd1:  s = 5'd12;  4'd2:  s = 5'd17;  4'd3:  s = 5'd22;
			4'd4:  s = 5'd5;   4'd5:  s = 5'd9;   4'd6:  s = 5'd14;  4'd7:  s = 5'd20;
			4'd8:  s = 5'd4;   4'd9:  s = 5'd11;  4'd10: s = 5'd16;  4'd11: s = 5'd23;
			4'd12: s = 5'd6;   4'd13: s = 5'd10;  4'd14: s = 5'd15;  4'd15: s = 5'd21;
			default: s = 5'd0;
		endcase
		return s;
	endfunction

	// message word index per round, all mod 16
	function automatic logic [3:0] pick_idx(input logic [5:0] r);
		logic [3:0] i;
		logic [3:0] p;
		i = r[3:0];
		case (r[5:4])
			2'd0:    p = i;
			2'd1:    p = 4'((i << 2) + i + 4'd1);
			2'd2:    p = 4'((i << 1) + i + 4'd5);
			default: p = 4'((i << 3) - i);
		endcase
		return p;
	endfunction

endpackage

`default_nettype wire

>>> hdl/md5_seq.sv
// ----------------------------------------------------------------------------
// md5_seq
// Microcode sequencer: step counter, return register and the control ROM
// that drives the digest datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module md5_seq (
	input  wire             clk,
	input  wire             arst_n,
	input  wire md5_pkg::cond_t cond,
	output md5_pkg::ctl_t   ctl
);
	import md5_pkg::*;

	localparam step_t ST_FETCH = 3'd0;
	localparam step_t ST_PAD80 = 3'd1;
	localparam step_t ST_ZFILL = 3'd2;
	localparam step_t ST_LENLO = 3'd3;
	localparam step_t ST_LENHI = 3'd4;
	localparam step_t ST_EMIT  = 3'd5;
	localparam step_t ST_ROUND = 3'd6;
	localparam step_t ST_FOLD  = 3'd7;

	step_t pc_q;
	step_t ret_q;
	step_t nat;

	function automatic ctl_t rom(input step_t pc);
		ctl_t c;
		c = '{push_mode: PUSH_NONE, dsel: DSEL_ZERO, round_en: 1'b0, fold_en: 1'b0,
			emit_en: 1'b0, jmode: J_NEXT, target: ST_FETCH};
		case (pc)
			ST_FETCH: begin
				c.push_mode = PUSH_FIRE;   c.dsel = DSEL_IN;    c.jmode = J_FETCH;
			end
			ST_PAD80: begin
				c.push_mode = PUSH_ALWAYS; c.dsel = DSEL_PAD;   c.target = ST_ZFILL;
			end
			ST_ZFILL: begin
				c.push_mode = PUSH_UNLESS; c.dsel = DSEL_ZERO;
				c.jmode = J_ZFILL;         c.target = ST_LENLO;
			end
			ST_LENLO: begin
				c.push_mode = PUSH_ALWAYS; c.dsel = DSEL_LENLO; c.target = ST_LENHI;
			end
			ST_LENHI: begin
				c.push_mode = PUSH_ALWAYS; c.dsel = DSEL_LENHI; c.target = ST_EMIT;
			end
			ST_EMIT: begin
				c.emit_en = 1'b1;   c.jmode = J_EMIT;  c.target = ST_FETCH;
			end
			ST_ROUND: begin
				c.round_en = 1'b1;  c.jmode = J_ROUND; c.target = ST_FOLD;
			end
			ST_FOLD: begin
				c.fold_en = 1'b1;   c.jmode = J_RET;
			end
			default: c.jmode = J_NEXT;
		endcase
		return c;
	endfunction

	assign ctl = rom(pc_q);

	always_comb begin
		case (ctl.jmode)
			J_FETCH: begin
				if (!cond.in_fire)
					nat = pc_q;
				else if (!cond.in_last)
					nat = ST_FETCH;
				else
					nat = cond.in_full ? ST_PAD80 : ST_ZFILL;
			end
			J_NEXT:  nat = ctl.target;
			J_ZFILL: nat = cond.pos14 ? ctl.target : pc_q;
			J_ROUND: nat = cond.round_last ? ctl.target : pc_q;
			J_RET:   nat = ret_q;
			J_EMIT:  nat = (cond.out_fire && cond.out_final) ? ctl.target : pc_q;
			default: nat = ST_FETCH;
		endcase
	end

	// a push that fills the block calls the compression and comes back after it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q  <= ST_FETCH;
			ret_q <= ST_FETCH;
		end else if (cond.wrap) begin
			pc_q  <= ST_ROUND;
			ret_q <= nat;
		end else begin
			pc_q  <= nat;
		end
	end

endmodule

`default_nettype wire

>>> hdl/md5_message_digest_unit.sv
// ----------------------------------------------------------------------------
// md5_message_digest_unit
// MD5 (RFC 1321) over a stream of little-endian 32-bit words, with padding
// and length appended on the last word and the digest given as four words.
// ----------------------------------------------------------------------------
// Usage:
//   msg channel (msg_valid/msg_ready) takes one message word per handshake,
//   first byte in bits 7:0. valid_bytes counts the bytes of the word that
//   carries last_word; other words always count as four bytes.
//   digest channel (digest_valid/digest_ready) then gives the four chaining
//   words, word_index 0 to 3, last_of_digest on the fourth.
// Timing:
//   a word that does not finish a block is only written to the block buffer.
//   The word that finishes a block starts a compression of 64 rounds and a
//   fold step, one MD5 round per cycle on the shared round unit, taking no
//   message word. After the last word, the padding steps push one word per
//   cycle (pad, zero fill, length), held while a compression runs; one or two
//   compressions follow; digest words come out one per cycle unless stalled.
//   msg_ready is low from the last word until the fourth digest word is taken.
// Reset and stall:
//   reset loads the MD5 initial chaining values and an empty block; the same
//   state is restored after each digest. A stalled receiver holds the current
//   digest word and no new message word is taken meanwhile.
// ----------------------------------------------------------------------------
`default_nettype none

module md5_message_digest_unit (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         msg_valid,
	output logic        msg_ready,
	input  wire  [31:0] message_word,
	input  wire  [2:0]  valid_bytes,
	input  wire         last_word,
	output logic        digest_valid,
	input  wire         digest_ready,
	output logic [31:0] digest_word,
	output logic [1:0]  word_index,
	output logic        last_of_digest
);
	import md5_pkg::*;

	ctl_t  ctl;
	cond_t cond;

	logic [31:0] chain_q [4];
	logic [31:0] blk_q [16];
	logic [31:0] a_q, b_q, c_q, d_q;
	logic [3:0]  pos_q;
	logic [60:0] count_q;
	logic [5:0]  round_q;
	logic [1:0]  emit_q;

	logic        in_fire, out_fire, push, wrap, full;
	logic [2:0]  add_bytes;
	logic [31:0] padded, push_data;
	logic [31:0] mix, sum, next_b;
	logic [63:0] rot64;

	md5_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.cond   (cond),
		.ctl    (ctl)
	);

	assign msg_ready = (ctl.push_mode == PUSH_FIRE);
	assign in_fire   = msg_valid && msg_ready;
	assign out_fire  = digest_valid && digest_ready;
	assign full      = (valid_bytes >= 3'd4);

	always_comb begin
		case (ctl.push_mode)
			PUSH_FIRE:   push = in_fire;
			PUSH_ALWAYS: push = 1'b1;
			PUSH_UNLESS: push = (pos_q != 4'd14);
			default:     push = 1'b0;
		endcase
	end

	assign wrap = push && (pos_q == 4'd15);

	assign cond = '{in_fire: in_fire, in_last: last_word, in_full: full, wrap: wrap,
		pos14: (pos_q == 4'd14), round_last: (round_q == 6'd63),
		out_fire: out_fire, out_final: (emit_q == 2'd3)};

	// last word: keep the valid low bytes, then the pad byte; a full word stays as it is
	always_comb begin
		if (full) begin
			padded = message_word;
		end else begin
			case (valid_bytes[1:0])
				2'd0:    padded = 32'h0000_0080;
				2'd1:    padded = {16'h0000, 8'h80, message_word[7:0]};
				2'd2:    padded = {8'h00, 8'h80, message_word[15:0]};
				default: padded = {8'h80, message_word[23:0]};
			endcase
		end
	end

	assign add_bytes = (!last_word || full) ? 3'd4 : {1'b0, valid_bytes[1:0]};

	always_comb begin
		case (ctl.dsel)
			DSEL_IN:    push_data = last_word ? padded : message_word;
			DSEL_PAD:   push_data = 32'h0000_0080;
			DSEL_LENLO: push_data = {count_q[28:0], 3'b000};
			DSEL_LENHI: push_data = count_q[60:29];
			default:    push_data = 32'h0;
		endcase
	end

	// one md5 round
	always_comb begin
		case (round_q[5:4])
			2'd0:    mix = (b_q & c_q) | (~b_q & d_q);
			2'd1:    mix = (b_q & d_q) | (c_q & ~d_q);
			2'd2:    mix = b_q ^ c_q ^ d_q;
			default: mix = c_q ^ (b_q | ~d_q);
		endcase
		sum    = a_q + mix + round_k(round_q) + blk_q[pick_idx(round_q)];
		rot64  = {sum, sum} << rot_amt(round_q);
		next_b = b_q + rot64[63:32];
	end

	always_ff @(posedge clk) begin
		if (push)
			blk_q[pos_q] <= push_data;
	end

	always_ff @(posedge clk) begin
		if (wrap) begin
			a_q <= chain_q[0];
			b_q <= chain_q[1];
			c_q <= chain_q[2];
			d_q <= chain_q[3];
		end else if (ctl.round_en) begin
			a_q <= d_q;
			d_q <= c_q;
			c_q <= b_q;
			b_q <= next_b;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chain_q[0] <= INIT_A;
			chain_q[1] <= INIT_B;
			chain_q[2] <= INIT_C;
			chain_q[3] <= INIT_D;
			pos_q      <= 4'd0;
			count_q    <= 61'd0;
			round_q    <= 6'd0;
			emit_q     <= 2'd0;
		end else begin
			if (push)
				pos_q <= pos_q + 4'd1;
			if (in_fire)
				count_q <= count_q + {58'd0, add_bytes};
			if (ctl.round_en)
				round_q <= round_q + 6'd1;
			if (ctl.fold_en) begin
				chain_q[0] <= chain_q[0] + a_q;
				chain_q[1] <= chain_q[1] + b_q;
				chain_q[2] <= chain_q[2] + c_q;
				chain_q[3] <= chain_q[3] + d_q;
			end
			if (out_fire) begin
				emit_q <= emit_q + 2'd1;
				if (emit_q == 2'd3) begin
					chain_q[0] <= INIT_A;
					chain_q[1] <= INIT_B;
					chain_q[2] <= INIT_C;
					chain_q[3] <= INIT_D;
					count_q    <= 61'd0;
				end
			end
		end
	end

	assign digest_valid   = ctl.emit_en;
	assign digest_word    = chain_q[emit_q];
	assign word_index     = emit_q;
	assign last_of_digest = (emit_q == 2'd3);

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(digest_valid && msg_ready))
		else $error("digest word shown while message words are taken");

	a_round_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!ctl.round_en |-> round_q == 6'd0)
		else $error("round counter left nonzero outside compression");

	a_last_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && last_word) |=> !msg_ready)
		else $error("word taken during padding");

	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(out_fire && last_of_digest) |=>
			(msg_ready && pos_q == 4'd0 && count_q == 61'd0 && chain_q[0] == INIT_A))
		else $error("state not restored after digest");

endmodule

`default_nettype wire

>>> tb/md5_message_digest_unit_tb.sv
// ----------------------------------------------------------------------------
// md5_message_digest_unit_tb
// Self-checking bench for the word-serial MD5 unit. A short table of known
// messages and corner cases for padding and byte counts runs first. Random
// messages of mixed lengths follow, some of them crossing block boundaries.
// Every digest word is checked against a known digest or an in-bench MD5
// predictor; both channels idle at random, except in the last random phase.
// ----------------------------------------------------------------------------
module md5_message_digest_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [31:0] word;
		logic [2:0]  nbytes;
		logic        last;
		logic        known;
		logic [3:0][31:0] digest;
	} dir_row_t;

	typedef struct packed {
		logic [31:0] word;
		logic [1:0]  index;
		logic        final_word;
	} digest_t;

	localparam logic [31:0] SINE_K [64] = '{
		32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
		32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
		32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
		32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
		32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
		32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
		32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
		32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
		32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
		32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
		32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
		32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
		32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
		32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
		32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
		32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
	};

	localparam int SHIFT_AMT [16] = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};

	localparam logic [31:0] IV_A = 32'h67452301;
	localparam logic [31:0] IV_B = 32'hefcdab89;
	localparam logic [31:0] IV_C = 32'h98badcfe;
	localparam logic [31:0] IV_D = 32'h10325476;

	localparam int N_DIR = 14;
	localparam int N_RANDOM_WORDS = 230;

	// digests of "" and "abc", first chaining word in the low slot
	localparam dir_row_t DIR_ROWS [N_DIR] = '{
		{32'hffffffff, 3'd0, 1'b1, 1'b1,
			{32'h7e42f8ec, 32'h980980e9, 32'h04b2008f, 32'hd98c1dd4}},
		{32'hff636261, 3'd3, 1'b1, 1'b1,
			{32'h727fe128, 32'h7d3f96d6, 32'hb04fd23c, 32'h98500190}},
		{32'h00000000, 3'd1, 1'b1, 1'b0, 128'h0},
		{32'hffffffff, 3'd2, 1'b1, 1'b0, 128'h0},
		{32'hffffffff, 3'd4, 1'b1, 1'b0, 128'h0},
		{32'ha5a5a5a5, 3'd5, 1'b1, 1'b0, 128'h0},
		{32'h5a5a5a5a, 3'd6, 1'b1, 1'b0, 128'h0},
		{32'h00000000, 3'd7, 1'b1, 1'b0, 128'h0},
		{32'hffffffff, 3'd0, 1'b0, 1'b0, 128'h0},
		{32'h00000000, 3'd4, 1'b1, 1'b0, 128'h0},
		{32'h00000000, 3'd7, 1'b0, 1'b0, 128'h0},
		{32'hffffffff, 3'd3, 1'b0, 1'b0, 128'h0},
		{32'h12345678, 3'd5, 1'b0, 1'b0, 128'h0},
		{32'hdeadbeef, 3'd0, 1'b1, 1'b0, 128'h0}
	};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        msg_valid = 1'b0;
	logic        msg_ready;
	logic [31:0] message_word = '0;
	logic [2:0]  valid_bytes = '0;
	logic        last_word = 1'b0;
	logic        digest_valid;
	logic        digest_ready = 1'b0;
	logic [31:0] digest_word;
	logic [1:0]  word_index;
	logic        last_of_digest;

	// predictor state
	logic [31:0] hash_chain [4];
	logic [31:0] hash_block [16];
	logic [3:0]  hash_pos;
	logic [60:0] hash_bytes;

	digest_t pending_digests [$];
	digest_t want;
	int      fail_count = 0;
	int      words_sent = 0;
	int      src_gap_pct = 18;
	int      sink_stall_pct = 85;

	md5_message_digest_unit u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.msg_valid      (msg_valid),
		.msg_ready      (msg_ready),
		.message_word   (message_word),
		.valid_bytes    (valid_bytes),
		.last_word      (last_word),
		.digest_valid   (digest_valid),
		.digest_ready   (digest_ready),
		.digest_word    (digest_word),
		.word_index     (word_index),
		.last_of_digest (last_of_digest)
	);

	always #5 clk = ~clk;

	function automatic logic [31:0] rotl32(input logic [31:0] x, input int s);
		return (x << s) | (x >> (32 - s));
	endfunction

	task automatic hash_restart();
		hash_chain[0] = IV_A;
		hash_chain[1] = IV_B;
		hash_chain[2] = IV_C;
		hash_chain[3] = IV_D;
		hash_pos = '0;
		hash_bytes = '0;
	endtask

	task automatic hash_compress();
		logic [31:0] a, b, c, d, f, nb;
		int g;
		int stage;
		a = hash_chain[0];
		b = hash_chain[1];
		c = hash_chain[2];
		d = hash_chain[3];
		for (int r = 0; r < 64; r++) begin
			stage = r / 16;
			case (stage)
				0: begin
					f = (b & c) | (~b & d);
					g = r;
				end
				1: begin
					f = (b & d) | (c & ~d);
					g = (5 * r + 1) % 16;
				end
				2: begin
					f = b ^ c ^ d;
					g = (3 * r + 5) % 16;
				end
				default: begin
					f = c ^ (b | ~d);
					g = (7 * r) % 16;
				end
			endcase
			nb = b + rotl32(a + f + SINE_K[r] + hash_block[g], SHIFT_AMT[stage * 4 + r % 4]);
			a = d;
			d = c;
			c = b;
			b = nb;
		end
		hash_chain[0] += a;
		hash_chain[1] += b;
		hash_chain[2] += c;
		hash_chain[3] += d;
	endtask

	task automatic hash_push(input logic [31:0] w);
		hash_block[hash_pos] = w;
		hash_pos = hash_pos + 4'd1;
		if (hash_pos == 4'd0)
			hash_compress();
	endtask

	// absorbs one accepted word; on the last word queues the four digest words
	task automatic hash_absorb(input logic [31:0] w, input logic [2:0] nb, input logic last,
			input logic known, input logic [3:0][31:0] known_digest);
		int n;
		logic [31:0] keep;
		logic [63:0] bit_len;
		if (!last) begin
			hash_bytes = hash_bytes + 61'd4;
			hash_push(w);
		end else begin
			n = (nb > 3'd4) ? 4 : int'(nb);
			hash_bytes = hash_bytes + 61'(n);
			if (n < 4) begin
				keep = (32'h1 << (8 * n)) - 32'h1;
				hash_push((w & keep) | (32'h80 << (8 * n)));
			end else begin
				hash_push(w);
				hash_push(32'h80);
			end
			// no room for the length: pad out this block and start another
			if (hash_pos > 4'd14)
				while (hash_pos != 4'd0)
					hash_push(32'h0);
			while (hash_pos < 4'd14)
				hash_push(32'h0);
			bit_len = {hash_bytes, 3'b000};
			hash_push(bit_len[31:0]);
			hash_push(bit_len[63:32]);
			for (int i = 0; i < 4; i++)
				pending_digests.push_back('{known ? known_digest[i] : hash_chain[i], 2'(i), i == 3});
			hash_restart();
		end
	endtask

	task automatic send_word(input logic [31:0] w, input logic [2:0] nb, input logic last,
			input logic known, input logic [3:0][31:0] known_digest);
		while ($urandom_range(99) < src_gap_pct) begin
			msg_valid <= 1'b0;
			@(posedge clk);
		end
		msg_valid <= 1'b1;
		message_word <= w;
		valid_bytes <= nb;
		last_word <= last;
		@(posedge clk);
		while (!msg_ready)
			@(posedge clk);
		hash_absorb(w, nb, last, known, known_digest);
		words_sent++;
	endtask

	// hold the sender off until every queued digest word is out
	task automatic drain_digests();
		msg_valid <= 1'b0;
		@(posedge clk);
		while (pending_digests.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic [31:0] pick_word();
		case ($urandom_range(9))
			0: return 32'h0;
			1: return 32'hffffffff;
			default: return $urandom;
		endcase
	endfunction

	always @(posedge clk)
		digest_ready <= ($urandom_range(99) >= sink_stall_pct);

	always @(posedge clk) begin
		if (arst_n && digest_valid && digest_ready) begin
			if (pending_digests.size() == 0) begin
				$error("unexpected digest word %h index %0d", digest_word, word_index);
				fail_count++;
			end else begin
				want = pending_digests.pop_front();
				if (digest_word !== want.word) begin
					$error("digest_word: expected %h, got %h", want.word, digest_word);
					fail_count++;
				end
				if (word_index !== want.index) begin
					$error("word_index: expected %0d, got %0d", want.index, word_index);
					fail_count++;
				end
				if (last_of_digest !== want.final_word) begin
					$error("last_of_digest: expected %0b, got %0b", want.final_word,
						last_of_digest);
					fail_count++;
				end
			end
		end
	end

	initial begin
		#5_000_000;
		$display("md5_message_digest_unit regression: fail");
		$finish;
	end

	initial begin
		int msg_len;
		int phase;
		logic [2:0] nb;
		hash_restart();
		for (int i = 0; i < 16; i++)
			hash_block[i] = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < N_DIR; i++)
			send_word(DIR_ROWS[i].word, DIR_ROWS[i].nbytes, DIR_ROWS[i].last,
				DIR_ROWS[i].known, DIR_ROWS[i].digest);
		drain_digests();

		phase = 0;
		words_sent = 0;
		while (words_sent < N_RANDOM_WORDS) begin
			if (phase == 0 && words_sent >= N_RANDOM_WORDS / 3) begin
				drain_digests();
				phase = 1;
				src_gap_pct = 85;
				sink_stall_pct = 18;
			end else if (phase == 1 && words_sent >= 2 * N_RANDOM_WORDS / 3) begin
				drain_digests();
				phase = 2;
				src_gap_pct = 0;
				sink_stall_pct = 0;
			end
			// mostly short messages, some around one block, a few spanning several
			case ($urandom_range(9))
				0, 1, 2, 3, 4: msg_len = $urandom_range(1, 4);
				5, 6, 7:       msg_len = $urandom_range(13, 18);
				8:             msg_len = $urandom_range(29, 34);
				default:       msg_len = $urandom_range(1, 60);
			endcase
			for (int k = 0; k < msg_len - 1; k++)
				send_word(pick_word(), 3'($urandom_range(7)), 1'b0, 1'b0, '0);
			nb = ($urandom_range(3) == 0) ? 3'($urandom_range(7)) : 3'($urandom_range(1, 4));
			send_word(pick_word(), nb, 1'b1, 1'b0, '0);
		end

		drain_digests();
		repeat (200) @(posedge clk);
		if (fail_count == 0)
			$display("md5_message_digest_unit regression: pass");
		else
			$display("md5_message_digest_unit regression: fail");
		$finish;
	end

endmodule
